FILE: hw/rtl/ssrs_pkg.sv
// Shared types, constants and codes for the solve and relay sequencer.
// No dependencies; every other file in hw/rtl imports this package.
package ssrs_pkg;

    // Fixed sizes that follow from the beat fields
    localparam int SENSOR_COUNT   = 10;
    localparam int RELAY_COUNT    = 3;
    localparam int DELAY_BITS_DEF = 16;
    localparam int SOLVE_DELAY_W  = 8;
    localparam int TYPE_W         = 3 * SENSOR_COUNT;
    localparam int CFG_IDX_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TYPES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_POL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READER_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLVE_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_ON_DLY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_OFF_DLY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_NC      = 3'd6;

    // Sensor type codes
    localparam logic [2:0] KIND_READER = 3'd1;
    localparam logic [2:0] KIND_IR     = 3'd2;
    localparam logic [2:0] KIND_HALL   = 3'd4;

    // Reported solve state codes
    localparam logic [1:0] SOLVE_NONE    = 2'd0;
    localparam logic [1:0] SOLVE_DELAYED = 2'd1;
    localparam logic [1:0] SOLVE_CHECK   = 2'd2;
    localparam logic [1:0] SOLVE_DONE    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DELAY  = 4'b0010,
        S_CHECK  = 4'b0100,
        S_SOLVED = 4'b1000
    } t_solve_state;

    typedef enum logic [4:0] {
        R_OFF      = 5'b00001,
        R_ON_RUN   = 5'b00010,
        R_ON_DONE  = 5'b00100,
        R_OFF_RUN  = 5'b01000,
        R_OFF_DONE = 5'b10000
    } t_relay_state;

    // Input beat: a poll or a one-second tick
    typedef struct packed {
        logic                    action;
        logic [SENSOR_COUNT-1:0] sensor_levels;
        logic [SENSOR_COUNT-1:0] card_seen;
        logic [SENSOR_COUNT-1:0] card_matched;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [RELAY_COUNT-1:0] relay_drive;
        logic [1:0]             solve_state;
        logic                   condition_met;
    } t_out_beat;

    // Per-relay control from the solve sequencer
    typedef struct packed {
        logic en;      // commit next state
        logic tick;    // count timers down
        logic arm;     // load on-delay timers (solve just reached)
        logic handle;  // advance expired timers (solved poll)
    } t_relay_ctl;

    function automatic logic [1:0] solve_code(input t_solve_state st);
        logic [1:0] code;
        case (st)
            S_IDLE:   code = SOLVE_NONE;
            S_DELAY:  code = SOLVE_DELAYED;
            S_CHECK:  code = SOLVE_CHECK;
            S_SOLVED: code = SOLVE_DONE;
            default:  code = SOLVE_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: hw/rtl/sensor_solve_relay_sequencer_unit.sv
// Solve and relay sequencer. Each input beat is a poll (action 0) or a one-second tick
// (action 1) and yields exactly one result beat. A beat is captured in an input register
// and, as soon as the output is not stalled, the solve state, the solve countdown and all
// relay timers are updated in one step and the result is written to the output register:
// one beat per cycle sustained while the output is not stalled. That state update is the
// loop that sets the rate. Both registers hold when the output is stalled, and the input
// stalls only when the input register cannot move on. Configuration is written through a
// plain write port; the user must do so while the block is idle, which it does not enforce.
module sensor_solve_relay_sequencer_unit #(
    parameter int DELAY_BITS = ssrs_pkg::DELAY_BITS_DEF,
    localparam int CFG_W = (ssrs_pkg::TYPE_W > ssrs_pkg::RELAY_COUNT * DELAY_BITS)
                           ? ssrs_pkg::TYPE_W : ssrs_pkg::RELAY_COUNT * DELAY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ssrs_pkg::t_in_beat            i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ssrs_pkg::t_out_beat           o_out_beat,
    input  logic                          i_cfg_we,
    input  logic [ssrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data
);
    import ssrs_pkg::*;

    localparam int DLY_W = RELAY_COUNT * DELAY_BITS;

    // Configuration registers
    logic [TYPE_W-1:0]        r_types;
    logic [SENSOR_COUNT-1:0]  r_polarity;
    logic [SENSOR_COUNT-1:0]  r_reader_mask;
    logic [SOLVE_DELAY_W-1:0] r_solve_delay;
    logic [DLY_W-1:0]         r_on_delays;
    logic [DLY_W-1:0]         r_off_delays;
    logic [RELAY_COUNT-1:0]   r_nc_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_types       <= '0;
            r_polarity    <= '0;
            r_reader_mask <= '0;
            r_solve_delay <= '0;
            r_on_delays   <= '0;
            r_off_delays  <= '0;
            r_nc_mask     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENSOR_TYPES:  r_types       <= i_cfg_data[TYPE_W-1:0];
                CFG_SENSOR_POL:    r_polarity    <= i_cfg_data[SENSOR_COUNT-1:0];
                CFG_READER_MASK:   r_reader_mask <= i_cfg_data[SENSOR_COUNT-1:0];
                CFG_SOLVE_DELAY:   r_solve_delay <= i_cfg_data[SOLVE_DELAY_W-1:0];
                CFG_RELAY_ON_DLY:  r_on_delays   <= i_cfg_data[DLY_W-1:0];
                CFG_RELAY_OFF_DLY: r_off_delays  <= i_cfg_data[DLY_W-1:0];
                CFG_RELAY_NC:      r_nc_mask     <= i_cfg_data[RELAY_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // Input register and output register handshake
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out, n_out;
    logic      advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    // Unlock condition
    logic cond_met;

    ssrs_cond u_cond (
        .i_types       (r_types),
        .i_polarity    (r_polarity),
        .i_reader_mask (r_reader_mask),
        .i_levels      (r_in.sensor_levels),
        .i_seen        (r_in.card_seen),
        .i_matched     (r_in.card_matched),
        .o_met         (cond_met)
    );

    // Solve sequencing up to the relay step
    t_solve_state             r_solve_st, mid_solve_st, n_solve_st;
    logic [SOLVE_DELAY_W-1:0] r_solve_cd, n_solve_cd;
    t_relay_ctl               relay_ctl;
    logic                     poll_met;

    assign poll_met = !r_in.action && cond_met;

    always_comb begin
        mid_solve_st     = r_solve_st;
        n_solve_cd       = r_solve_cd;
        relay_ctl.en     = advance;
        relay_ctl.tick   = r_in.action;
        relay_ctl.arm    = 1'b0;
        relay_ctl.handle = 1'b0;
        if (r_in.action) begin
            if (r_solve_cd != '0) begin
                n_solve_cd = r_solve_cd - 1'b1;
                if (r_solve_cd == SOLVE_DELAY_W'(1)) mid_solve_st = S_CHECK;
            end
        end else begin
            if (cond_met) begin
                if (mid_solve_st == S_IDLE) begin
                    if (r_solve_delay != '0) begin
                        mid_solve_st = S_DELAY;
                        n_solve_cd   = r_solve_delay;
                    end else begin
                        mid_solve_st = S_CHECK;
                    end
                end
                if (mid_solve_st == S_CHECK) begin
                    mid_solve_st  = S_SOLVED;
                    relay_ctl.arm = 1'b1;
                end
            end else if (mid_solve_st != S_SOLVED) begin
                mid_solve_st = S_IDLE;
            end
            relay_ctl.handle = (mid_solve_st == S_SOLVED);
        end
    end

    // Relay channels
    logic [RELAY_COUNT-1:0] pin_next;
    logic [RELAY_COUNT-1:0] busy_next;

    for (genvar g = 0; g < RELAY_COUNT; g++) begin : g_relay
        ssrs_relay #(
            .DELAY_BITS (DELAY_BITS)
        ) u_relay (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (relay_ctl),
            .i_on_delay  (r_on_delays[g*DELAY_BITS +: DELAY_BITS]),
            .i_off_delay (r_off_delays[g*DELAY_BITS +: DELAY_BITS]),
            .i_nc        (r_nc_mask[g]),
            .o_pin_next  (pin_next[g]),
            .o_busy_next (busy_next[g])
        );
    end

    // Solved poll with every timer stopped drops back to not solved
    always_comb begin
        n_solve_st = mid_solve_st;
        if (relay_ctl.handle && busy_next == '0) n_solve_st = S_IDLE;
    end

    always_comb begin
        n_out.relay_drive   = pin_next;
        n_out.solve_state   = solve_code(n_solve_st);
        n_out.condition_met = poll_met;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solve_st  <= S_IDLE;
            r_solve_cd  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_solve_st  <= n_solve_st;
                r_solve_cd  <= n_solve_cd;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Checks
    a_delay_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_solve_st == S_DELAY |-> r_solve_cd != '0)
        else $error("solve delayed with countdown at zero");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed beat did not reach the output");

endmodule

FILE: hw/rtl/ssrs_cond.sv
// Unlock condition check over all sensors of one poll beat.
// Depends on ssrs_pkg.
module ssrs_cond (
    input  logic [ssrs_pkg::TYPE_W-1:0]       i_types,
    input  logic [ssrs_pkg::SENSOR_COUNT-1:0] i_polarity,
    input  logic [ssrs_pkg::SENSOR_COUNT-1:0] i_reader_mask,
    input  logic [ssrs_pkg::SENSOR_COUNT-1:0] i_levels,
    input  logic [ssrs_pkg::SENSOR_COUNT-1:0] i_seen,
    input  logic [ssrs_pkg::SENSOR_COUNT-1:0] i_matched,
    output logic                              o_met
);
    import ssrs_pkg::*;

    logic [SENSOR_COUNT-1:0] fail;

    // Per-sensor fail flags; touch and unknown types always pass
    always_comb begin
        logic [2:0] kind;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            kind    = i_types[3*i +: 3];
            fail[i] = 1'b0;
            case (kind)
                KIND_READER:
                    fail[i] = i_reader_mask[i] &&
                              !(i_polarity[i] && i_seen[i] && i_matched[i]);
                KIND_IR, KIND_HALL:
                    fail[i] = (i_levels[i] == i_polarity[i]);
                default:
                    fail[i] = 1'b0;
            endcase
        end
    end

    assign o_met = (fail == '0);

endmodule

FILE: hw/rtl/ssrs_relay.sv
// One relay channel: on-delay and off-delay timers and the pin level.
// Depends on ssrs_pkg.
module ssrs_relay #(
    parameter int DELAY_BITS = ssrs_pkg::DELAY_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ssrs_pkg::t_relay_ctl    i_ctl,
    input  logic [DELAY_BITS-1:0]   i_on_delay,
    input  logic [DELAY_BITS-1:0]   i_off_delay,
    input  logic                    i_nc,
    output logic                    o_pin_next,
    output logic                    o_busy_next
);
    import ssrs_pkg::*;

    t_relay_state          r_state, n_state;
    logic [DELAY_BITS-1:0] r_on_cd, n_on_cd;
    logic [DELAY_BITS-1:0] r_off_cd, n_off_cd;
    logic                  r_pin, n_pin;

    // Next state for a tick or a poll
    always_comb begin
        n_state  = r_state;
        n_on_cd  = r_on_cd;
        n_off_cd = r_off_cd;
        n_pin    = r_pin;
        if (i_ctl.tick) begin
            if (r_on_cd != '0) begin
                n_on_cd = r_on_cd - 1'b1;
                if (r_on_cd == DELAY_BITS'(1)) n_state = R_ON_DONE;
            end
            if (r_off_cd != '0) begin
                n_off_cd = r_off_cd - 1'b1;
                if (r_off_cd == DELAY_BITS'(1)) n_state = R_OFF_DONE;
            end
        end else begin
            // solve just reached: start the on-delay, zero switches at once
            if (i_ctl.arm) begin
                if (i_on_delay != '0) begin
                    n_on_cd = i_on_delay;
                    n_state = R_ON_RUN;
                end else begin
                    n_state = R_ON_DONE;
                end
            end
            if (i_ctl.handle) begin
                if (n_state == R_ON_DONE) begin
                    if (i_off_delay != '0) begin
                        n_pin    = i_nc;
                        n_off_cd = i_off_delay;
                        n_state  = R_OFF_RUN;
                    end else begin
                        n_state = R_OFF;
                    end
                end
                if (n_state == R_OFF_DONE) begin
                    n_pin   = !i_nc;
                    n_state = R_OFF;
                end
            end
        end
    end

    assign o_pin_next  = n_pin;
    assign o_busy_next = (n_on_cd != '0) || (n_off_cd != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= R_OFF;
            r_on_cd  <= '0;
            r_off_cd <= '0;
            r_pin    <= 1'b0;
        end else if (i_ctl.en) begin
            r_state  <= n_state;
            r_on_cd  <= n_on_cd;
            r_off_cd <= n_off_cd;
            r_pin    <= n_pin;
        end
    end

endmodule
